// ===== design/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and helper functions for the HTTP chunked body decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

    typedef enum logic [3:0] {
        PH_SIZE     = 4'd0,
        PH_SIZE_LF  = 4'd1,
        PH_DATA     = 4'd2,
        PH_DATA_CR  = 4'd3,
        PH_DATA_LF  = 4'd4,
        PH_TRAILER  = 4'd5,
        PH_TRAIL_LF = 4'd6,
        PH_DONE     = 4'd7,
        PH_FAILED   = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_FRAMING   = 3'd1,
        ERR_SIZE_LONG = 3'd2,
        ERR_SYNTAX    = 3'd3,
        ERR_LIMIT     = 3'd4,
        ERR_DATA_CRLF = 3'd5,
        ERR_TRAILER   = 3'd6,
        ERR_CLOSE     = 3'd7
    } err_t;

    typedef enum logic [1:0] {
        MODE_BYTE  = 2'd0,
        MODE_CLOSE = 2'd1,
        MODE_NEW   = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    localparam logic [1:0] REG_BODY_LIMIT    = 2'd0;
    localparam logic [1:0] REG_SIZE_LINE_MAX = 2'd1;
    localparam logic [1:0] REG_TRAILER_MAX   = 2'd2;

    localparam logic [23:0] BODY_LIMIT_RST    = 24'd1048576;
    localparam logic [7:0]  SIZE_LINE_MAX_RST = 8'd128;
    localparam logic [15:0] TRAILER_MAX_RST   = 16'd8192;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    endfunction

    // Bit 4 set means the octet is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/http_chunked_body_decoder_top.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Decodes an HTTP chunked body one octet per transfer, one result per input.
// ----------------------------------------------------------------------------
// A result is registered on the master side in the cycle after its input
// transfer. Throughput: one input per cycle, set by the single parse-state
// update; the input side stalls only while an unread result is held back.
// Reset (aresetn low, synchronous) returns the parse state to the first size
// line, clears the error and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // tdata: byte_value[7:0]
    input  wire logic [7:0]  s_tdata,
    // tuser: mode[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: data_byte[7:0], error_code[10:8], body_length[34:11], zero pad
    output logic [39:0]      m_tdata,
    // tuser: data_valid[0], done_res[1], failed[2]
    output logic [2:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import hcbd_pkg::*;

    logic [23:0] body_limit_reg;
    logic [7:0]  size_line_max_reg;
    logic [15:0] trailer_max_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] chunk_reg, chunk_next;
    logic [23:0] body_count_reg, body_count_next;
    logic [15:0] line_count_reg, line_count_next;
    logic        digits_reg, digits_next;
    logic        gap_reg, gap_next;
    err_t        err_reg, err_next;

    err_t        err_now;
    logic        dv_now, done_now;

    logic        m_valid_reg;
    logic [7:0]  data_byte_reg;
    logic        data_valid_reg, done_reg, failed_reg;
    err_t        err_out_reg;
    logic [23:0] body_len_reg;

    logic        s_fire;
    mode_t       mode;
    logic [7:0]  c;
    logic [4:0]  hv;
    logic [31:0] allow;
    logic [31:0] grown;

    assign mode     = mode_t'(s_tuser);
    assign c        = s_tdata;
    assign hv       = hex_value(c);
    // Wraps like the unsigned difference if the limit was lowered mid-body.
    assign allow    = {8'd0, body_limit_reg} - {8'd0, body_count_reg};
    assign grown    = {chunk_reg[27:0], hv[3:0]};

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_limit_reg    <= BODY_LIMIT_RST;
            size_line_max_reg <= SIZE_LINE_MAX_RST;
            trailer_max_reg   <= TRAILER_MAX_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BODY_LIMIT:    body_limit_reg    <= cfg_data[23:0];
                REG_SIZE_LINE_MAX: size_line_max_reg <= cfg_data[7:0];
                REG_TRAILER_MAX:   trailer_max_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Next parse state and the error raised by this input.
    always_comb begin
        phase_next      = phase_reg;
        chunk_next      = chunk_reg;
        body_count_next = body_count_reg;
        line_count_next = line_count_reg;
        digits_next     = digits_reg;
        gap_next        = gap_reg;
        err_now         = ERR_NONE;
        unique case (mode)
            MODE_NEW: begin
                phase_next      = PH_SIZE;
                chunk_next      = '0;
                body_count_next = '0;
                line_count_next = '0;
                digits_next     = 1'b0;
                gap_next        = 1'b0;
            end
            MODE_CLOSE: begin
                if (phase_reg != PH_DONE && phase_reg != PH_FAILED) begin
                    err_now = ERR_CLOSE;
                end
            end
            MODE_BYTE: begin
                unique case (phase_reg)
                    PH_SIZE: begin
                        priority if (c == CH_CR) begin
                            if (!digits_reg) err_now = ERR_SYNTAX;
                            else phase_next = PH_SIZE_LF;
                        end else if (c == CH_LF) begin
                            err_now = ERR_FRAMING;
                        end else if (line_count_reg >= {8'd0, size_line_max_reg}) begin
                            err_now = ERR_SIZE_LONG;
                        end else begin
                            line_count_next = line_count_reg + 16'd1;
                            priority if (is_ws(c)) begin
                                if (digits_reg) gap_next = 1'b1;
                            end else if (!hv[4] && !gap_reg) begin
                                if (grown > allow) begin
                                    err_now = ERR_LIMIT;
                                end else begin
                                    chunk_next  = grown;
                                    digits_next = 1'b1;
                                end
                            end else begin
                                err_now = ERR_SYNTAX;
                            end
                        end
                    end
                    PH_SIZE_LF: begin
                        priority if (c != CH_LF) begin
                            err_now = ERR_FRAMING;
                        end else if (chunk_reg == 32'd0) begin
                            phase_next      = PH_TRAILER;
                            line_count_next = '0;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        body_count_next = body_count_reg + 24'd1;
                        chunk_next      = {8'd0, chunk_reg[23:0] - 24'd1};
                        if (chunk_reg[23:0] == 24'd1) phase_next = PH_DATA_CR;
                    end
                    PH_DATA_CR: begin
                        if (c != CH_CR) err_now = ERR_DATA_CRLF;
                        else phase_next = PH_DATA_LF;
                    end
                    PH_DATA_LF: begin
                        if (c != CH_LF) begin
                            err_now = ERR_DATA_CRLF;
                        end else begin
                            phase_next      = PH_SIZE;
                            chunk_next      = '0;
                            line_count_next = '0;
                            digits_next     = 1'b0;
                            gap_next        = 1'b0;
                        end
                    end
                    PH_TRAILER: begin
                        priority if (c == CH_CR) begin
                            phase_next = PH_TRAIL_LF;
                        end else if (c == CH_LF) begin
                            err_now = ERR_FRAMING;
                        end else if (line_count_reg >= trailer_max_reg) begin
                            err_now = ERR_TRAILER;
                        end else begin
                            line_count_next = line_count_reg + 16'd1;
                        end
                    end
                    PH_TRAIL_LF: begin
                        priority if (c != CH_LF) begin
                            err_now = ERR_FRAMING;
                        end else if (line_count_reg == 16'd0) begin
                            phase_next = PH_DONE;
                        end else begin
                            phase_next      = PH_TRAILER;
                            line_count_next = '0;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (err_now != ERR_NONE) phase_next = PH_FAILED;
    end

    // Latched error code and the per-input result flags.
    always_comb begin
        err_next = err_reg;
        if (mode == MODE_NEW) err_next = ERR_NONE;
        if (err_now != ERR_NONE) err_next = err_now;
        dv_now   = (mode == MODE_BYTE) && (phase_reg == PH_DATA);
        done_now = (mode == MODE_BYTE) && (phase_reg == PH_TRAIL_LF) &&
                   (c == CH_LF) && (line_count_reg == 16'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SIZE;
            chunk_reg      <= '0;
            body_count_reg <= '0;
            line_count_reg <= '0;
            digits_reg     <= 1'b0;
            gap_reg        <= 1'b0;
            err_reg        <= ERR_NONE;
        end else if (s_fire) begin
            phase_reg      <= phase_next;
            chunk_reg      <= chunk_next;
            body_count_reg <= body_count_next;
            line_count_reg <= line_count_next;
            digits_reg     <= digits_next;
            gap_reg        <= gap_next;
            err_reg        <= err_next;
        end
    end

    // Result register; a new transfer may load it while the old one is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            data_valid_reg <= dv_now;
            data_byte_reg  <= dv_now ? c : 8'd0;
            done_reg       <= done_now;
            failed_reg     <= (err_now != ERR_NONE);
            err_out_reg    <= err_next;
            body_len_reg   <= body_count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, body_len_reg, err_out_reg, data_byte_reg};
    assign m_tuser  = {failed_reg, done_reg, data_valid_reg};

    a_failed_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && failed_reg |-> err_out_reg != ERR_NONE)
        else $error("failed result without an error code");

    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && done_reg |-> err_out_reg == ERR_NONE && !failed_reg && !data_valid_reg)
        else $error("completion reported together with an error or payload");

    a_failed_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FAILED) == (err_reg != ERR_NONE))
        else $error("failed phase and latched error disagree");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid_reg)
        else $error("accepted input produced no result");

    a_error_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> err_out_reg == err_reg)
        else $error("reported error code differs from latched code");

endmodule

`default_nettype wire

// ===== tb/chunk_decode_checker.sv =====
// ----------------------------------------------------------------------------
// chunk_decode_checker
// Watches the byte, result and register channels of the chunked body decoder.
// It keeps its own copy of the parse state and the register values, predicts
// one decoded result for every input transfer and compares each result
// transfer, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chunk_decode_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic [2:0]  m_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               mismatches,
    output int               results_seen,
    output int               outstanding
);
    import hcbd_pkg::*;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        done_res;
        logic        failed;
        err_t        error_code;
        logic [23:0] body_length;
    } decoded_t;

    decoded_t decoded_q[$];

    // Register copies.
    logic [23:0] limit;
    logic [7:0]  size_max;
    logic [15:0] trail_max;

    // Parse state copies.
    phase_t      stage;
    logic [31:0] remaining;
    logic [23:0] body_cnt;
    logic [15:0] line_len;
    logic        seen_digit;
    logic        gap;
    err_t        latched;

    initial begin
        mismatches   = 0;
        results_seen = 0;
        outstanding  = 0;
    end

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    endfunction

    // Values 0 to 15 for hex digits; 16 for anything else.
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
        if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
        return 5'd16;
    endfunction

    task automatic clear_body();
        stage      = PH_SIZE;
        remaining  = '0;
        body_cnt   = '0;
        line_len   = '0;
        seen_digit = 1'b0;
        gap        = 1'b0;
        latched    = ERR_NONE;
    endtask

    task automatic decode_octet(input mode_t mode, input logic [7:0] c, output decoded_t r);
        err_t        err;
        logic [4:0]  nib;
        logic [31:0] allowance;
        logic [31:0] grown;
        err = ERR_NONE;
        r   = '0;
        case (mode)
            MODE_NEW: clear_body();
            MODE_CLOSE: begin
                if (stage != PH_DONE && stage != PH_FAILED) err = ERR_CLOSE;
            end
            MODE_BYTE: begin
                case (stage)
                    PH_SIZE: begin
                        if (c == CH_CR) begin
                            if (!seen_digit) err = ERR_SYNTAX;
                            else stage = PH_SIZE_LF;
                        end else if (c == CH_LF) begin
                            err = ERR_FRAMING;
                        end else if (line_len >= {8'd0, size_max}) begin
                            err = ERR_SIZE_LONG;
                        end else begin
                            nib      = digit_of(c);
                            line_len = line_len + 16'd1;
                            if (is_space(c)) begin
                                if (seen_digit) gap = 1'b1;
                            end else if (!nib[4] && !gap) begin
                                // The chunk may not outgrow what is left of the body allowance.
                                allowance = {8'd0, limit} - {8'd0, body_cnt};
                                grown     = remaining * 32'd16 + {27'd0, nib};
                                if (grown > allowance) begin
                                    err = ERR_LIMIT;
                                end else begin
                                    remaining  = grown;
                                    seen_digit = 1'b1;
                                end
                            end else begin
                                err = ERR_SYNTAX;
                            end
                        end
                    end
                    PH_SIZE_LF: begin
                        if (c != CH_LF) begin
                            err = ERR_FRAMING;
                        end else if (remaining == 32'd0) begin
                            stage    = PH_TRAILER;
                            line_len = '0;
                        end else begin
                            stage = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        r.data_valid = 1'b1;
                        r.data_byte  = c;
                        body_cnt     = body_cnt + 24'd1;
                        remaining    = {8'd0, remaining[23:0] - 24'd1};
                        if (remaining == 32'd0) stage = PH_DATA_CR;
                    end
                    PH_DATA_CR: begin
                        if (c != CH_CR) err = ERR_DATA_CRLF;
                        else stage = PH_DATA_LF;
                    end
                    PH_DATA_LF: begin
                        if (c != CH_LF) begin
                            err = ERR_DATA_CRLF;
                        end else begin
                            stage      = PH_SIZE;
                            remaining  = '0;
                            line_len   = '0;
                            seen_digit = 1'b0;
                            gap        = 1'b0;
                        end
                    end
                    PH_TRAILER: begin
                        if (c == CH_CR) stage = PH_TRAIL_LF;
                        else if (c == CH_LF) err = ERR_FRAMING;
                        else if (line_len >= trail_max) err = ERR_TRAILER;
                        else line_len = line_len + 16'd1;
                    end
                    PH_TRAIL_LF: begin
                        if (c != CH_LF) begin
                            err = ERR_FRAMING;
                        end else if (line_len == 16'd0) begin
                            stage      = PH_DONE;
                            r.done_res = 1'b1;
                        end else begin
                            stage    = PH_TRAILER;
                            line_len = '0;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (err != ERR_NONE) begin
            latched = err;
            stage   = PH_FAILED;
        end
        r.failed      = (err != ERR_NONE);
        r.error_code  = latched;
        r.body_length = body_cnt;
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        decoded_t want;
        decoded_t fresh;
        if (!aresetn) begin
            limit     = BODY_LIMIT_RST;
            size_max  = SIZE_LINE_MAX_RST;
            trail_max = TRAILER_MAX_RST;
            clear_body();
            decoded_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    $error("result transfer arrived with no prediction waiting");
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("data_valid", want.data_valid, m_tuser[0]);
                    check_field("data_byte", want.data_byte, m_tdata[7:0]);
                    check_field("done_res", want.done_res, m_tuser[1]);
                    check_field("failed", want.failed, m_tuser[2]);
                    check_field("error_code", want.error_code, m_tdata[10:8]);
                    check_field("body_length", want.body_length, m_tdata[34:11]);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BODY_LIMIT:    limit     = cfg_data[23:0];
                    REG_SIZE_LINE_MAX: size_max  = cfg_data[7:0];
                    REG_TRAILER_MAX:   trail_max = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                decode_octet(mode_t'(s_tuser), s_tdata, fresh);
                decoded_q.insert(decoded_q.size(), fresh);
            end
        end
        outstanding <= decoded_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the HTTP chunked body decoder. A short directed
// run covers the named corner cases and register extremes, then three random
// phases send mostly well-formed chunked bodies, some corrupted, under changing
// register settings and idle patterns; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import hcbd_pkg::*;

    localparam int HOLD_CYCLES = 200;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic [1:0]  s_tuser   = MODE_NOP;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_BODY_LIMIT;
    logic [31:0] cfg_data  = 32'd0;

    int mismatches;
    int results_seen;
    int outstanding;

    int   snd_idle   = 27;
    int   rcv_idle   = 69;
    int   sent_items = 0;
    int   target;
    logic hold_req   = 1'b0;
    logic hold_ack   = 1'b0;
    int   hold_left  = 0;

    logic [7:0] body_octets[$];

    http_chunked_body_decoder_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    chunk_decode_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .results_seen (results_seen),
        .outstanding  (outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off whenever the stimulus asks for one.
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    task automatic send_item(input mode_t m, input logic [7:0] b);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= (m == MODE_BYTE) ? b : 8'($urandom);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    // Pauses the sender until every predicted result has been taken.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Writes every register index once; unused bits carry random junk.
    task automatic set_regs(input logic [23:0] limit, input logic [7:0] line_max,
                            input logic [15:0] trail_max);
        logic [1:0]  idx;
        logic [31:0] word;
        idx = REG_BODY_LIMIT;
        repeat (4) begin
            case (idx)
                REG_BODY_LIMIT:    word = {8'($urandom), limit};
                REG_SIZE_LINE_MAX: word = {24'($urandom), line_max};
                REG_TRAILER_MAX:   word = {16'($urandom), trail_max};
                default:           word = $urandom;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= word;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            idx++;
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(3))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    task automatic add_octet(input logic [7:0] b);
        body_octets.insert(body_octets.size(), b);
    endtask

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++) add_octet(txt[i]);
    endtask

    task automatic add_crlf();
        add_octet(CH_CR);
        add_octet(CH_LF);
    endtask

    task automatic add_size_line(input logic [23:0] sz);
        int         sh;
        logic [3:0] nib;
        if ($urandom_range(3) == 0) add_octet(pick_space());
        if ($urandom_range(3) == 0) add_octet(8'h30);
        sh = 20;
        while (sh > 0 && sz[sh +: 4] == 4'd0) sh -= 4;
        while (sh >= 0) begin
            nib = sz[sh +: 4];
            if (nib < 4'd10) add_octet(8'h30 + {4'd0, nib});
            else add_octet(($urandom_range(1) ? 8'h61 : 8'h41) + {4'd0, nib} - 8'd10);
            sh -= 4;
        end
        if ($urandom_range(3) == 0) add_octet(pick_space());
        add_crlf();
    endtask

    task automatic send_octets();
        foreach (body_octets[i]) send_item(MODE_BYTE, body_octets[i]);
        body_octets.delete();
    endtask

    // One body: up to three chunks, optional trailer lines, sometimes corrupted or cut short.
    task automatic send_random_body(input int max_chunk);
        int   sz;
        int   pos;
        logic closing;
        closing = 1'b0;
        body_octets.delete();
        repeat ($urandom_range(3)) begin
            sz = ($urandom_range(19) == 0) ? $urandom_range(10 * max_chunk, max_chunk)
                                           : $urandom_range(max_chunk, 1);
            add_size_line(sz[23:0]);
            repeat (sz) add_octet(8'($urandom));
            add_crlf();
        end
        add_size_line(24'd0);
        repeat ($urandom_range(2)) begin
            repeat ($urandom_range(6, 1)) add_octet(8'($urandom_range(8'h7E, 8'h20)));
            add_crlf();
        end
        add_crlf();
        if ($urandom_range(4) == 0) begin
            pos = $urandom_range(body_octets.size() - 1);
            case ($urandom_range(3))
                0: body_octets[pos] = 8'($urandom);
                1: body_octets[pos] = CH_LF;
                2: body_octets.insert(pos, 8'($urandom));
                default: begin
                    while (body_octets.size() > pos) body_octets.delete(body_octets.size() - 1);
                    closing = 1'b1;
                end
            endcase
        end
        send_item(MODE_NEW, 8'h00);
        send_octets();
        if (closing) send_item(MODE_CLOSE, 8'h00);
        // Occasional noise after the body.
        case ($urandom_range(19))
            0:       send_item(MODE_NOP, 8'h00);
            1:       send_item(MODE_CLOSE, 8'h00);
            2:       send_item(MODE_BYTE, 8'($urandom));
            default: ;
        endcase
    endtask

    initial begin
        logic paused;
        paused = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset register values.
        send_item(MODE_NOP, 8'hA5);
        send_item(MODE_NEW, 8'h00);
        add_text(" 1 ");
        add_crlf();
        add_octet(8'hFF);
        add_crlf();
        add_text("0");
        add_crlf();
        add_text("x");
        add_crlf();
        add_crlf();
        add_octet(8'h00);
        send_octets();
        send_item(MODE_CLOSE, 8'h00);
        // A bare LF, then a byte that the failed state ignores.
        send_item(MODE_NEW, 8'h00);
        send_item(MODE_BYTE, CH_LF);
        send_item(MODE_BYTE, 8'h31);
        // An extension after the size.
        send_item(MODE_NEW, 8'h00);
        add_text("1;");
        send_octets();
        // A size line with no digits fails at its CR.
        send_item(MODE_NEW, 8'h00);
        send_item(MODE_BYTE, CH_CR);
        send_item(MODE_NEW, 8'h00);
        send_item(MODE_CLOSE, 8'h00);
        wait_drain();

        // Zero line maximum and zero body allowance.
        set_regs(24'd0, 8'd0, 16'd0);
        send_item(MODE_NEW, 8'h00);
        send_item(MODE_BYTE, 8'h30);
        wait_drain();
        set_regs(24'd0, 8'd1, 16'd0);
        send_item(MODE_NEW, 8'h00);
        send_item(MODE_BYTE, 8'h31);
        send_item(MODE_NEW, 8'h00);
        add_text("0");
        add_crlf();
        add_text("x");
        send_octets();
        // A CR in the size line followed by something other than LF.
        send_item(MODE_NEW, 8'h00);
        add_text("0");
        add_octet(CH_CR);
        add_text("z");
        send_octets();
        wait_drain();

        // Random phase one: widest settings, sender idles less than receiver.
        set_regs(24'hFFFFFF, 8'd255, 16'hFFFF);
        target = sent_items + 470;
        while (sent_items < target) begin
            send_random_body(40);
            if (!paused && sent_items > target - 235) begin
                wait_drain();
                paused = 1'b1;
            end
        end
        wait_drain();

        // Random phase two: tight limits, idle ratios swapped.
        snd_idle = 69;
        rcv_idle = 27;
        set_regs(24'd64, 8'd6, 16'd5);
        target = sent_items + 470;
        while (sent_items < target) send_random_body(20);
        wait_drain();

        // Random phase three: no idling, with one long receiver hold-off at the start.
        snd_idle = 0;
        rcv_idle = 0;
        set_regs(24'($urandom_range(5000, 200)), 8'($urandom_range(40, 8)),
                 16'($urandom_range(100, 3)));
        hold_req <= ~hold_req;
        target = sent_items + 470;
        while (sent_items < target) send_random_body(12);
        wait_drain();
        repeat (4) @(posedge aclk);

        $display("Sent %0d input transfers and checked %0d results,", sent_items, results_seen);
        $display("covering directed corner cases and three random phases with varied limits.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/hcbd_pkg.sv
design/http_chunked_body_decoder_top.sv
tb/chunk_decode_checker.sv
tb/tb_top.sv
